### rtl/gfw_pkg.sv
`timescale 1ns / 1ps
// Package for the glyph frame buffer writer: store geometry, item and register codes,
// and the 5x8 font table. No dependencies.
package gfw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_PAGES   = 8;
  localparam int STORE_DEPTH = MAX_COLUMNS * MAX_PAGES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GLYPH_FIRST = 32;
  localparam int GLYPH_LAST  = 126;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 8;
  localparam int ADVANCE     = 6;
  localparam int EXP_W       = 128;

  localparam logic [1:0] KIND_DRAW  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_PAGES = 1'b1;

  // Five column bytes of one character, leftmost column in the top byte.
  function automatic logic [39:0] glyph_cols(input logic [6:0] idx);
    logic [39:0] g;
    case (idx)
      7'd0:  g = 40'h0000000000; 7'd1:  g = 40'h00005F0000; 7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14; 7'd4:  g = 40'h242A7F2A12; 7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250; 7'd7:  g = 40'h0005030000; 7'd8:  g = 40'h001C224100;
      7'd9:  g = 40'h0041221C00; 7'd10: g = 40'h14083E0814; 7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000; 7'd13: g = 40'h0808080808; 7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402; 7'd16: g = 40'h3E5149453E; 7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946; 7'd19: g = 40'h2141454B31; 7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539; 7'd22: g = 40'h3C4A494930; 7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936; 7'd25: g = 40'h064949291E; 7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000; 7'd28: g = 40'h0814224100; 7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408; 7'd31: g = 40'h0201510906; 7'd32: g = 40'h3E415D594E;
      7'd33: g = 40'h7C1211127C; 7'd34: g = 40'h7F49494936; 7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141413E; 7'd37: g = 40'h7F49494941; 7'd38: g = 40'h7F09090901;
      7'd39: g = 40'h3E41415132; 7'd40: g = 40'h7F0808087F; 7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01; 7'd43: g = 40'h7F08142241; 7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F020C027F; 7'd46: g = 40'h7F0408107F; 7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906; 7'd49: g = 40'h3E4151215E; 7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h2649494932; 7'd52: g = 40'h01017F0101; 7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F; 7'd55: g = 40'h3F4038403F; 7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807; 7'd58: g = 40'h6151494543; 7'd59: g = 40'h007F414100;
      7'd60: g = 40'h0204081020; 7'd61: g = 40'h0041417F00; 7'd62: g = 40'h0402010204;
      7'd63: g = 40'h8080808080; 7'd64: g = 40'h0003040000; 7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438; 7'd67: g = 40'h3844444420; 7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418; 7'd70: g = 40'h087E090102; 7'd71: g = 40'h0C5252523E;
      7'd72: g = 40'h7F08040478; 7'd73: g = 40'h00447D4000; 7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h7F10284400; 7'd76: g = 40'h00417F4000; 7'd77: g = 40'h7C04780478;
      7'd78: g = 40'h7C08040478; 7'd79: g = 40'h3844444438; 7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C; 7'd82: g = 40'h7C08040408; 7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020; 7'd85: g = 40'h3C4040207C; 7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C; 7'd88: g = 40'h4428102844; 7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44; 7'd91: g = 40'h0008364141; 7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h4141360800; 7'd94: g = 40'h0201020402;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

### rtl/gfw_ram.sv
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module gfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### rtl/glyph_framebuffer_writer.sv
`timescale 1ns / 1ps
// Top level of the glyph frame buffer writer.
// Depends on gfw_pkg and gfw_ram.
//
// Usage: one input channel (item_valid / item_stall) carries draw, clear and
// read transactions; one output channel (result_valid / result_stall) returns
// one byte for each read transaction. Draw and clear give no result.
// The frame store is one 1024 x 8 RAM, page-organized: the byte at page*width+column
// holds eight vertical pixels. All draw traffic is read-modify-write on that one port.
// Throughput: one item at a time. A read goes through the issue, data and output
// states before it loads the result register, and waits in the output state while
// an earlier result is still held by a stall. A clear sweeps the whole RAM. A draw
// at scale s builds the scaled column pattern for each glyph column, then for each
// of the 5*s pixel columns spends a setup state plus a read state and a write state
// for every page the glyph covers. Columns past the display width end the glyph early.
// Reset: rst is synchronous and active high. After reset the block runs the same
// clearing pass and holds item_stall high until it is done; configuration writes
// are taken during that pass. Registers reset to width 128, 8 pages.
// A stalled result stays in the output register; the block may still finish the
// current item and accept the next, and only a second read waits for the register.
module glyph_framebuffer_writer
  import gfw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] kind,
  input  logic [7:0] char_code,
  input  logic       first_of_string,
  input  logic [7:0] start_column,
  input  logic [7:0] start_row,
  input  logic [3:0] glyph_scale,
  input  logic [2:0] read_page,
  input  logic [6:0] read_column,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] read_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EXPAND, S_COLUMN, S_READ, S_WRITE, S_RD_ISSUE, S_RD_DATA, S_RD_OUT
  } state_t;

  state_t             state;
  logic [7:0]         display_width;
  logic [3:0]         display_pages;
  logic [7:0]         cur_col;
  logic [7:0]         cur_row;
  logic [ADDR_W-1:0]  clr_addr;
  logic [6:0]         code_idx;
  logic [3:0]         scale;
  logic [2:0]         glyph_col;
  logic [3:0]         sub_col;
  logic [6:0]         x_off;
  logic [2:0]         bit_idx;
  logic [EXP_W-1:0]   pattern;
  logic [2:0]         page;
  logic [2:0]         rd_page;
  logic [6:0]         rd_col;
  logic [7:0]         rd_hold;

  // Effective geometry.
  logic [7:0] w_use;
  logic [3:0] p_use;
  assign w_use = (display_width > 8'(MAX_COLUMNS)) ? 8'(MAX_COLUMNS) : display_width;
  assign p_use = (display_pages > 4'(MAX_PAGES)) ? 4'(MAX_PAGES) : display_pages;

  // Pages spanned by the scaled glyph, clipped to the pages in use.
  logic [8:0] row_end;
  logic [5:0] pg_end;
  logic [4:0] pg_lo;
  logic [3:0] pg_lim;
  logic       pg_empty;
  logic [2:0] pg_hi;
  assign row_end  = {1'b0, cur_row} + {2'b0, scale, 3'b0} - 9'd1;
  assign pg_end   = row_end[8:3];
  assign pg_lo    = cur_row[7:3];
  assign pg_lim   = p_use - 4'd1;
  assign pg_empty = (p_use == 4'd0) || ({1'b0, pg_lo} > {1'b0, pg_lim});
  assign pg_hi    = (pg_end < {2'b0, pg_lim}) ? pg_end[2:0] : pg_lim[2:0];

  logic [8:0] x_abs;
  assign x_abs = {1'b0, cur_col} + {2'b0, x_off};

  // Current font column byte and the scaled bit run it contributes.
  logic [39:0] rom_word;
  logic [7:0]  col_byte;
  logic [15:0] run_ones;
  assign rom_word = glyph_cols(code_idx);
  assign col_byte = 8'(rom_word >> (6'd8 * (6'd4 - {3'b0, glyph_col})));
  assign run_ones = 16'((17'd1 << scale) - 17'd1);

  // Frame store access.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [10:0]       draw_addr;
  logic [10:0]       read_addr;
  assign draw_addr = 11'(page) * 11'(w_use) + 11'(x_abs[6:0]);
  assign read_addr = 11'(rd_page) * 11'(w_use) + 11'(rd_col);

  // Merge the scaled glyph column into the byte read back from the store.
  logic [7:0] new_byte;
  always_comb begin
    logic signed [9:0] diff;
    new_byte = ram_rdata;
    for (int n = 0; n < GLYPH_ROWS; n++) begin
      diff = $signed({4'b0, page, 3'(n)}) - $signed({2'b0, cur_row});
      if (diff >= 0 && diff < $signed({3'b0, scale, 3'b0})) begin
        new_byte[n] = pattern[diff[6:0]];
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = new_byte;
    ram_addr  = draw_addr[ADDR_W-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = 8'd0;
        ram_addr  = clr_addr;
      end
      S_WRITE:    ram_we = 1'b1;
      S_RD_ISSUE: ram_addr = read_addr[ADDR_W-1:0];
      default:    ram_we = 1'b0;
    endcase
  end

  gfw_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign item_stall = (state != S_IDLE);

  logic [8:0] adv;
  assign adv = {1'b0, cur_col} + 9'(scale) * 9'(ADVANCE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      display_width <= 8'(MAX_COLUMNS);
      display_pages <= 4'(MAX_PAGES);
      cur_col       <= '0;
      cur_row       <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_WIDTH: display_width <= cfg_data;
          CFG_PAGES: display_pages <= cfg_data[3:0];
          default:   display_width <= display_width;
        endcase
      end
      // The output state loads the register itself, so it handles its own drain.
      if (result_valid && !result_stall && state != S_RD_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            case (kind)
              KIND_DRAW: begin
                if (first_of_string) begin
                  cur_col <= start_column;
                  cur_row <= start_row;
                end
                code_idx  <= (char_code >= 8'(GLYPH_FIRST) && char_code <= 8'(GLYPH_LAST))
                             ? 7'(char_code - 8'(GLYPH_FIRST)) : 7'd0;
                scale     <= glyph_scale;
                glyph_col <= '0;
                sub_col   <= '0;
                x_off     <= '0;
                bit_idx   <= 3'd7;
                pattern   <= '0;
                if (glyph_scale != 4'd0) begin
                  state <= S_EXPAND;
                end
              end
              KIND_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLEAR;
              end
              KIND_READ: begin
                rd_page <= read_page;
                rd_col  <= read_column;
                state   <= S_RD_ISSUE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_EXPAND: begin
          // Font row 7 goes in first, so font row j lands at pattern bits j*s .. j*s+s-1.
          pattern <= (pattern << scale) | EXP_W'(run_ones & {16{col_byte[bit_idx]}});
          bit_idx <= bit_idx - 1'b1;
          if (bit_idx == 3'd0) begin
            state <= S_COLUMN;
          end
        end
        S_COLUMN: begin
          if (x_abs >= {1'b0, w_use} || pg_empty || pg_lo > 5'(pg_hi)) begin
            cur_col <= (adv > 9'd255) ? 8'd255 : adv[7:0];
            state   <= S_IDLE;
          end else begin
            page  <= pg_lo[2:0];
            state <= S_READ;
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          if (page != pg_hi) begin
            page  <= page + 1'b1;
            state <= S_READ;
          end else begin
            x_off <= x_off + 1'b1;
            if (sub_col == scale - 4'd1) begin
              sub_col <= '0;
              if (glyph_col == 3'(GLYPH_COLS - 1)) begin
                cur_col <= (adv > 9'd255) ? 8'd255 : adv[7:0];
                state   <= S_IDLE;
              end else begin
                glyph_col <= glyph_col + 1'b1;
                bit_idx   <= 3'd7;
                pattern   <= '0;
                state     <= S_EXPAND;
              end
            end else begin
              sub_col <= sub_col + 1'b1;
              state   <= S_COLUMN;
            end
          end
        end
        S_RD_ISSUE: state <= S_RD_DATA;
        S_RD_DATA: begin
          rd_hold <= ({1'b0, rd_col} < w_use && {1'b0, rd_page} < p_use) ? ram_rdata : 8'd0;
          state   <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            read_data    <= rd_hold;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/gfw_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the glyph frame buffer writer, bound to the top level.
// Depends on gfw_pkg.
module gfw_checker
  import gfw_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic [1:0] kind,
  input logic       result_valid,
  input logic       result_stall
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk) rst |=> item_stall && !result_valid)
    else $error("block not clearing after reset");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == KIND_CLEAR |=> item_stall)
    else $error("clear transaction did not start a sweep");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == KIND_READ |=> item_stall ##1 item_stall)
    else $error("read transaction finished too early");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && kind == KIND_CLEAR && !result_valid |=> !result_valid)
    else $error("result appeared without a read");

endmodule

bind glyph_framebuffer_writer gfw_checker u_gfw_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .kind         (kind),
  .result_valid (result_valid),
  .result_stall (result_stall)
);

### verif/tb_glyph_framebuffer_writer.sv
`timescale 1ns / 1ps
// Self-checking testbench for glyph_framebuffer_writer: a directed table followed by
// random text strings, reads and clears, checked against a built-in frame store model.
// Depends on gfw_pkg and the RTL of the block.
module tb_glyph_framebuffer_writer;
  import gfw_pkg::*;

  // Kind code that the block must ignore without a result.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Longest single transaction (scale 15 over eight pages, or a clear) plus margin.
  localparam int SETTLE_CYCLES = 1600;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_code;
    logic       first_of_string;
    logic [7:0] start_column;
    logic [7:0] start_row;
    logic [3:0] glyph_scale;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } text_item_t;

  // One directed row; known_byte is the typed expectation for a read when has_known is set.
  typedef struct packed {
    text_item_t item;
    logic       has_known;
    logic [7:0] known_byte;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  logic       cfg_index = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  logic       item_valid = 1'b0;
  logic       item_stall;
  logic [1:0] kind = KIND_DRAW;
  logic [7:0] char_code = 8'd0;
  logic       first_of_string = 1'b0;
  logic [7:0] start_column = 8'd0;
  logic [7:0] start_row = 8'd0;
  logic [3:0] glyph_scale = 4'd1;
  logic [2:0] read_page = 3'd0;
  logic [6:0] read_column = 7'd0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] read_data;

  glyph_framebuffer_writer dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .char_code(char_code), .first_of_string(first_of_string),
    .start_column(start_column), .start_row(start_row), .glyph_scale(glyph_scale),
    .read_page(read_page), .read_column(read_column),
    .result_valid(result_valid), .result_stall(result_stall), .read_data(read_data)
  );

  always #6 clk = ~clk;

  // Font: five column bytes per printable character, codes 32 through 126.
  logic [7:0] font [0:474] = '{
    8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00, 8'h00,8'h07,8'h00,8'h07,8'h00,
    8'h14,8'h7F,8'h14,8'h7F,8'h14, 8'h24,8'h2A,8'h7F,8'h2A,8'h12, 8'h23,8'h13,8'h08,8'h64,8'h62,
    8'h36,8'h49,8'h55,8'h22,8'h50, 8'h00,8'h05,8'h03,8'h00,8'h00, 8'h00,8'h1C,8'h22,8'h41,8'h00,
    8'h00,8'h41,8'h22,8'h1C,8'h00, 8'h14,8'h08,8'h3E,8'h08,8'h14, 8'h08,8'h08,8'h3E,8'h08,8'h08,
    8'h00,8'h50,8'h30,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08, 8'h00,8'h60,8'h60,8'h00,8'h00,
    8'h20,8'h10,8'h08,8'h04,8'h02, 8'h3E,8'h51,8'h49,8'h45,8'h3E, 8'h00,8'h42,8'h7F,8'h40,8'h00,
    8'h42,8'h61,8'h51,8'h49,8'h46, 8'h21,8'h41,8'h45,8'h4B,8'h31, 8'h18,8'h14,8'h12,8'h7F,8'h10,
    8'h27,8'h45,8'h45,8'h45,8'h39, 8'h3C,8'h4A,8'h49,8'h49,8'h30, 8'h01,8'h71,8'h09,8'h05,8'h03,
    8'h36,8'h49,8'h49,8'h49,8'h36, 8'h06,8'h49,8'h49,8'h29,8'h1E, 8'h00,8'h36,8'h36,8'h00,8'h00,
    8'h00,8'h56,8'h36,8'h00,8'h00, 8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,
    8'h00,8'h41,8'h22,8'h14,8'h08, 8'h02,8'h01,8'h51,8'h09,8'h06, 8'h3E,8'h41,8'h5D,8'h59,8'h4E,
    8'h7C,8'h12,8'h11,8'h12,8'h7C, 8'h7F,8'h49,8'h49,8'h49,8'h36, 8'h3E,8'h41,8'h41,8'h41,8'h22,
    8'h7F,8'h41,8'h41,8'h41,8'h3E, 8'h7F,8'h49,8'h49,8'h49,8'h41, 8'h7F,8'h09,8'h09,8'h09,8'h01,
    8'h3E,8'h41,8'h41,8'h51,8'h32, 8'h7F,8'h08,8'h08,8'h08,8'h7F, 8'h00,8'h41,8'h7F,8'h41,8'h00,
    8'h20,8'h40,8'h41,8'h3F,8'h01, 8'h7F,8'h08,8'h14,8'h22,8'h41, 8'h7F,8'h40,8'h40,8'h40,8'h40,
    8'h7F,8'h02,8'h0C,8'h02,8'h7F, 8'h7F,8'h04,8'h08,8'h10,8'h7F, 8'h3E,8'h41,8'h41,8'h41,8'h3E,
    8'h7F,8'h09,8'h09,8'h09,8'h06, 8'h3E,8'h41,8'h51,8'h21,8'h5E, 8'h7F,8'h09,8'h19,8'h29,8'h46,
    8'h26,8'h49,8'h49,8'h49,8'h32, 8'h01,8'h01,8'h7F,8'h01,8'h01, 8'h3F,8'h40,8'h40,8'h40,8'h3F,
    8'h1F,8'h20,8'h40,8'h20,8'h1F, 8'h3F,8'h40,8'h38,8'h40,8'h3F, 8'h63,8'h14,8'h08,8'h14,8'h63,
    8'h07,8'h08,8'h70,8'h08,8'h07, 8'h61,8'h51,8'h49,8'h45,8'h43, 8'h00,8'h7F,8'h41,8'h41,8'h00,
    8'h02,8'h04,8'h08,8'h10,8'h20, 8'h00,8'h41,8'h41,8'h7F,8'h00, 8'h04,8'h02,8'h01,8'h02,8'h04,
    8'h80,8'h80,8'h80,8'h80,8'h80, 8'h00,8'h03,8'h04,8'h00,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,
    8'h7F,8'h48,8'h44,8'h44,8'h38, 8'h38,8'h44,8'h44,8'h44,8'h20, 8'h38,8'h44,8'h44,8'h48,8'h7F,
    8'h38,8'h54,8'h54,8'h54,8'h18, 8'h08,8'h7E,8'h09,8'h01,8'h02, 8'h0C,8'h52,8'h52,8'h52,8'h3E,
    8'h7F,8'h08,8'h04,8'h04,8'h78, 8'h00,8'h44,8'h7D,8'h40,8'h00, 8'h20,8'h40,8'h44,8'h3D,8'h00,
    8'h7F,8'h10,8'h28,8'h44,8'h00, 8'h00,8'h41,8'h7F,8'h40,8'h00, 8'h7C,8'h04,8'h78,8'h04,8'h78,
    8'h7C,8'h08,8'h04,8'h04,8'h78, 8'h38,8'h44,8'h44,8'h44,8'h38, 8'h7C,8'h14,8'h14,8'h14,8'h08,
    8'h08,8'h14,8'h14,8'h18,8'h7C, 8'h7C,8'h08,8'h04,8'h04,8'h08, 8'h48,8'h54,8'h54,8'h54,8'h20,
    8'h04,8'h3F,8'h44,8'h40,8'h20, 8'h3C,8'h40,8'h40,8'h20,8'h7C, 8'h1C,8'h20,8'h40,8'h20,8'h1C,
    8'h3C,8'h40,8'h30,8'h40,8'h3C, 8'h44,8'h28,8'h10,8'h28,8'h44, 8'h0C,8'h50,8'h50,8'h50,8'h3C,
    8'h44,8'h64,8'h54,8'h4C,8'h44, 8'h00,8'h08,8'h36,8'h41,8'h41, 8'h00,8'h00,8'h7F,8'h00,8'h00,
    8'h41,8'h41,8'h36,8'h08,8'h00, 8'h02,8'h01,8'h02,8'h04,8'h02
  };

  // Shadow copy of the block's state, updated as each transaction is accepted.
  logic [7:0] shadow_store [0:STORE_DEPTH-1];
  int         shadow_cursor_col;
  int         shadow_cursor_row;
  int         shadow_width;
  int         shadow_pages;

  logic [7:0] pending_bytes [$];   // read bytes still owed by the block
  int         error_count = 0;
  int         items_sent = 0;
  int         reads_checked = 0;
  int         draws_sent = 0;
  int         idle_pct = 19;       // percent chance of an idle cycle on each side
  int         quiet_cycles = 0;

  function automatic int used_width();
    return (shadow_width < MAX_COLUMNS) ? shadow_width : MAX_COLUMNS;
  endfunction

  function automatic int used_pages();
    return (shadow_pages < MAX_PAGES) ? shadow_pages : MAX_PAGES;
  endfunction

  // Set or clear one pixel; anything outside the area in use is dropped.
  function automatic void plot_pixel(int col, int row, bit on);
    int w;
    int addr;
    w = used_width();
    if (col >= w || row >= used_pages() * 8) return;
    addr = (row >> 3) * w + col;
    if (addr >= STORE_DEPTH) return;
    if (on) shadow_store[addr][row & 7] = 1'b1;
    else shadow_store[addr][row & 7] = 1'b0;
  endfunction

  function automatic void render_glyph(int code, int scale);
    int base;
    logic [7:0] bits;
    if (code < GLYPH_FIRST || code > GLYPH_LAST) code = GLYPH_FIRST;
    base = (code - GLYPH_FIRST) * GLYPH_COLS;
    for (int i = 0; i < GLYPH_COLS; i++) begin
      bits = font[base + i];
      for (int j = 0; j < GLYPH_ROWS; j++)
        for (int sx = 0; sx < scale; sx++)
          for (int sy = 0; sy < scale; sy++)
            plot_pixel(shadow_cursor_col + i * scale + sx,
                       shadow_cursor_row + j * scale + sy, bits[j]);
    end
    shadow_cursor_col = shadow_cursor_col + ADVANCE * scale;
    if (shadow_cursor_col > 255) shadow_cursor_col = 255;
  endfunction

  // Apply one accepted transaction to the shadow state; returns 1 with the byte for reads.
  function automatic bit apply_item(text_item_t it, output logic [7:0] byte_out);
    int w;
    int addr;
    byte_out = 8'd0;
    case (it.kind)
      KIND_DRAW: begin
        if (it.first_of_string) begin
          shadow_cursor_col = it.start_column;
          shadow_cursor_row = it.start_row;
        end
        render_glyph(it.char_code, it.glyph_scale);
        return 1'b0;
      end
      KIND_CLEAR: begin
        foreach (shadow_store[k]) shadow_store[k] = 8'd0;
        return 1'b0;
      end
      KIND_READ: begin
        w = used_width();
        addr = it.read_page * w + it.read_column;
        if (it.read_column < w && it.read_page < used_pages() && addr < STORE_DEPTH)
          byte_out = shadow_store[addr];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Present one transaction, idling at random first, and hold it until accepted.
  task automatic send_item(text_item_t it, bit has_known, logic [7:0] known_byte);
    logic [7:0] predicted;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid      <= 1'b1;
    kind            <= it.kind;
    char_code       <= it.char_code;
    first_of_string <= it.first_of_string;
    start_column    <= it.start_column;
    start_row       <= it.start_row;
    glyph_scale     <= it.glyph_scale;
    read_page       <= it.read_page;
    read_column     <= it.read_column;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
    if (it.kind == KIND_DRAW) draws_sent++;
    if (apply_item(it, predicted)) begin
      // Typed table values take the place of the prediction; a disagreement means
      // the shadow model itself is off, which is worth flagging too.
      if (has_known && known_byte !== predicted) begin
        $display("%0t: table expects %02h but shadow model gives %02h",
                 $time, known_byte, predicted);
        error_count++;
      end
      pending_bytes.push_back(has_known ? known_byte : predicted);
    end
  endtask

  // Registers are only written with the block idle: drain the results, then let the
  // longest possible draw or clear finish before touching them.
  task automatic write_config(int width_val, int pages_val);
    item_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= width_val[7:0];
    @(posedge clk);
    shadow_width = width_val & 8'hFF;
    cfg_index <= CFG_PAGES;
    cfg_data  <= pages_val[7:0];
    @(posedge clk);
    shadow_pages = pages_val & 4'hF;
    cfg_write <= 1'b0;
  endtask

  function automatic text_item_t make_item(logic [1:0] k, int ch, bit fs, int col, int row,
                                           int scale, int page, int rcol);
    text_item_t it;
    it.kind = k;
    it.char_code = ch;
    it.first_of_string = fs;
    it.start_column = col;
    it.start_row = row;
    it.glyph_scale = scale;
    it.read_page = page;
    it.read_column = rcol;
    return it;
  endfunction

  // Random stimulus: mostly strings of characters, most started in the first 128 columns
  // and 64 rows, with reads sprinkled between them, plus occasional clears and ignored kinds.
  task automatic random_phase(int count);
    text_item_t it;
    int left_in_string;
    int pick;
    int col;
    int row;
    int scale;
    int rcol;
    left_in_string = 0;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        it = make_item(KIND_UNUSED, $urandom_range(255), $urandom_range(1), $urandom_range(255),
                       $urandom_range(255), $urandom_range(15), $urandom_range(7),
                       $urandom_range(127));
      end else if (pick < 5) begin
        it = make_item(KIND_CLEAR, $urandom_range(255), $urandom_range(1), $urandom_range(255),
                       $urandom_range(255), $urandom_range(15), $urandom_range(7),
                       $urandom_range(127));
      end else if (pick < 38) begin
        // Read columns are steered into the width in use most of the time.
        rcol = ($urandom_range(9) < 7 && used_width() > 0) ?
               $urandom_range(used_width() - 1) : $urandom_range(127);
        it = make_item(KIND_READ, $urandom_range(255), $urandom_range(1), $urandom_range(255),
                       $urandom_range(255), $urandom_range(15), $urandom_range(7), rcol);
      end else begin
        if ($urandom_range(19) == 0) scale = $urandom_range(15);
        else scale = $urandom_range(3, 1);
        if ($urandom_range(9) < 7) begin
          col = $urandom_range(127);
          row = $urandom_range(63);
        end else begin
          col = $urandom_range(255);
          row = $urandom_range(255);
        end
        it = make_item(KIND_DRAW,
                       ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(126, 32),
                       (left_in_string == 0), col, row, scale, $urandom_range(7),
                       $urandom_range(127));
        if (left_in_string == 0) left_in_string = $urandom_range(8, 1);
        left_in_string--;
      end
      send_item(it, 1'b0, 8'd0);
    end
  endtask

  // Result side: random stall, and each accepted byte is checked against the oldest owed.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected read result, expected none, actual %02h",
                   $time, read_data);
          error_count++;
        end else begin
          if (read_data !== pending_bytes[0]) begin
            $display("%0t: read_data mismatch, expected %02h, actual %02h",
                     $time, pending_bytes[0], read_data);
            error_count++;
          end
          void'(pending_bytes.pop_front());
          reads_checked++;
        end
      end
      result_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d reads outstanding",
               $time, pending_bytes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  directed_row_t directed [] ;

  initial begin
    // Directed rows: reset contents, font extremes, unmapped codes, scale zero and the
    // largest scale, clipping off both edges, cursor saturation, page crossing, clear,
    // and the ignored kind.
    directed = '{
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 0, 0), 1'b1, 8'h00},
      '{make_item(KIND_DRAW, 8'h41, 1, 0, 0, 1, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 0, 0), 1'b1, 8'h7C},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 0, 1), 1'b1, 8'h12},
      '{make_item(KIND_DRAW, 8'h00, 0, 0, 0, 1, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'hFF, 0, 0, 0, 1, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'd126, 0, 0, 0, 1, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'd31, 0, 0, 0, 1, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'd127, 0, 0, 0, 2, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'h23, 1, 40, 20, 0, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'h40, 1, 100, 30, 15, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'h57, 1, 255, 255, 4, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'h57, 0, 255, 255, 8, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_DRAW, 8'h38, 1, 120, 60, 2, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_UNUSED, 8'hFF, 1, 255, 255, 15, 7, 127), 1'b0, 8'h00},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 7, 127), 1'b0, 8'h00},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 7, 121), 1'b0, 8'h00},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 4, 110), 1'b0, 8'h00},
      '{make_item(KIND_CLEAR, 8'hFF, 1, 255, 255, 15, 7, 127), 1'b0, 8'h00},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 3, 64), 1'b1, 8'h00},
      '{make_item(KIND_DRAW, 8'h5F, 1, 10, 0, 1, 0, 0), 1'b0, 8'h00},
      '{make_item(KIND_READ, 0, 0, 0, 0, 1, 0, 10), 1'b1, 8'h80}
    };

    foreach (shadow_store[k]) shadow_store[k] = 8'd0;
    shadow_cursor_col = 0;
    shadow_cursor_row = 0;
    shadow_width = MAX_COLUMNS;
    shadow_pages = MAX_PAGES;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[r]) send_item(directed[r].item, directed[r].has_known,
                                    directed[r].known_byte);

    // Random phases, each under its own geometry. The third runs with no idling at all.
    write_config(1, 1);
    random_phase(RANDOM_ITEMS / 8);
    write_config(64, 4);
    random_phase(RANDOM_ITEMS / 8);
    idle_pct = 0;
    write_config(128, 8);
    random_phase(RANDOM_ITEMS / 8);
    idle_pct = 19;
    write_config(0, 8);
    random_phase(RANDOM_ITEMS / 16);
    write_config(128, 0);
    random_phase(RANDOM_ITEMS / 16);
    write_config(255, 15);
    random_phase(RANDOM_ITEMS / 8);
    write_config($urandom_range(127, 1), $urandom_range(8, 1));
    random_phase(RANDOM_ITEMS / 8);
    write_config($urandom_range(255), $urandom_range(15));
    random_phase(RANDOM_ITEMS / 8);
    write_config(128, 8);
    random_phase(RANDOM_ITEMS / 8);

    item_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d draws) over nine geometries; %0d reads checked.",
             items_sent, draws_sent, reads_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
